FILE: hw/rtl/crdi2s_pkg.sv
package crdi2s_pkg;

  localparam logic [3:0] POS_FIRST   = 4'd0;
  localparam logic [3:0] POS_X_BEGIN = 4'd1;
  localparam logic [3:0] POS_X_END   = 4'd6;
  localparam logic [3:0] POS_Y_BEGIN = 4'd8;
  localparam logic [3:0] POS_Y_END   = 4'd13;
  localparam logic [3:0] POS_LAST    = 4'd14;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_COORD = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [15:0] BUFFER_WORDS = 16'd32768;

  // c = (200000 - v) * 8388607 / 200000 = 41 * d + d * 188607 / 200000
  localparam logic signed [21:0] CENTER   = 22'sd200000;
  localparam logic [17:0]        FRAC_MUL = 18'd188607;
  localparam logic [20:0]        RECIP    = 21'd1374389;
  localparam logic [33:0]        DIV_LO   = 34'd3125;

  localparam int SCALE_STAGES = 4;

  typedef logic [20:0]        val_t;
  typedef logic signed [20:0] coord_t;
  typedef logic signed [26:0] scaled_t;

  typedef struct packed {
    logic [15:0] out_word;
    logic        is_frame_end;
    logic [13:0] frame_length;
    logic        overflow;
    logic        last;
  } res_t;

endpackage

FILE: hw/rtl/crdi2s_if.sv
interface crdi2s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface crdi2s_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_word;
  logic        is_frame_end;
  logic [13:0] frame_length;
  logic        overflow;
  logic        last;

  modport source(output valid, output out_word, output is_frame_end, output frame_length,
                 output overflow, output last, input ready);
  modport sink(input valid, input out_word, input is_frame_end, input frame_length,
               input overflow, input last, output ready);
endinterface

FILE: hw/rtl/crdi2s_scale.sv
module crdi2s_scale (
  input  logic                     clk,
  input  crdi2s_pkg::coord_t       v,
  output crdi2s_pkg::scaled_t      c
);

  logic signed [21:0] d;
  logic [21:0]        d_neg;
  logic [20:0]        mag;

  logic [20:0] mag1_r;
  logic        neg1_r;
  logic [38:0] prod2_r;
  logic [26:0] base2_r;
  logic        neg2_r;
  logic [31:0] x3_r;
  logic [20:0] q3_r;
  logic [26:0] base3_r;
  logic        neg3_r;
  crdi2s_pkg::scaled_t c4_r;

  logic [52:0] est;
  logic [33:0] rem;
  logic [20:0] q_fix;
  logic [26:0] cabs;

  assign d     = crdi2s_pkg::CENTER - {v[20], v};
  assign d_neg = -d;
  assign mag   = d[21] ? d_neg[20:0] : d[20:0];

  assign est   = 53'(prod2_r[37:6]) * 53'(crdi2s_pkg::RECIP);
  assign rem   = 34'(x3_r) - 34'(q3_r) * crdi2s_pkg::DIV_LO;
  assign q_fix = q3_r + 21'(rem >= crdi2s_pkg::DIV_LO);
  assign cabs  = base3_r + 27'(q_fix);

  always_ff @(posedge clk) begin
    mag1_r  <= mag;
    neg1_r  <= d[21];
    prod2_r <= 39'(mag1_r) * 39'(crdi2s_pkg::FRAC_MUL);
    base2_r <= (27'(mag1_r) << 5) + (27'(mag1_r) << 3) + 27'(mag1_r);
    neg2_r  <= neg1_r;
    x3_r    <= prod2_r[37:6];
    q3_r    <= est[52:32];
    base3_r <= base2_r;
    neg3_r  <= neg2_r;
    c4_r    <= neg3_r ? -$signed(cabs) : $signed(cabs);
  end

  assign c = c4_r;

endmodule

FILE: hw/rtl/coordinate_record_to_i2s_words_top.sv
// The last byte of a record starts an event that runs through scaling into the result queue.
// Throughput: one byte per cycle while ready; a coordinate record queues four results.
// Input stalls while the 8-entry result queue has fewer than four free entries.
// Scaling runs through a 4-stage multiply pipeline per coordinate.
// Reset: synchronous active-low rst_n clears record position, parser, word count and the queue.
module coordinate_record_to_i2s_words_top (
  input  logic                clk,
  input  logic                rst_n,
  crdi2s_in_if.sink           in_ch,
  crdi2s_out_if.source        out_ch
);

  localparam int FIFO_DEPTH = 8;
  localparam int ADDR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;

  logic [3:0]  pos_r;
  logic [1:0]  kind_r;
  logic [1:0]  phase_r;
  logic        neg_r;
  crdi2s_pkg::val_t   val_r;
  crdi2s_pkg::coord_t xh_r;
  logic [15:0] wc_r;

  logic                ev_vld_r;
  logic                ev_frm_r;
  crdi2s_pkg::coord_t  ev_x_r;
  crdi2s_pkg::coord_t  ev_y_r;
  logic [crdi2s_pkg::SCALE_STAGES-1:0] tag_vld_r;
  logic [crdi2s_pkg::SCALE_STAGES-1:0] tag_frm_r;

  crdi2s_pkg::res_t    mem_r [FIFO_DEPTH];
  logic [ADDR_W-1:0]   wptr_r;
  logic [ADDR_W-1:0]   rptr_r;
  logic [CNT_W-1:0]    cnt_r;

  logic        in_acc;
  logic        out_acc;
  logic [7:0]  ch;
  logic        is_dig;
  logic        is_ws;
  logic [3:0]  dval;
  logic [1:0]  f_ph;
  logic        f_neg;
  crdi2s_pkg::val_t f_val;
  logic        in_field;
  logic [3:0]  pos_nxt;
  logic [1:0]  kind_nxt;
  logic [1:0]  phase_nxt;
  logic        neg_nxt;
  crdi2s_pkg::val_t   val_nxt;
  crdi2s_pkg::coord_t xh_nxt;
  logic        ev_vld_nxt;
  logic        ev_frm_nxt;

  crdi2s_pkg::scaled_t cx;
  crdi2s_pkg::scaled_t cy;

  logic              push_coord;
  logic              push_frame;
  logic [2:0]        push_n;
  crdi2s_pkg::res_t  wr_ent [4];
  logic [15:0]       wc_chain [5];
  logic [3:0]        ovf;
  logic [15:0]       wc_nxt;

  function automatic crdi2s_pkg::coord_t field_value(input logic neg, input crdi2s_pkg::val_t v);
    logic [20:0] nv;
    nv = -v;
    return neg ? crdi2s_pkg::coord_t'(nv) : crdi2s_pkg::coord_t'(v);
  endfunction

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign in_ch.ready = cnt_r <= CNT_W'(FIFO_DEPTH - 4);

  // field parser, one byte
  always_comb begin
    ch     = in_ch.rx_byte;
    is_dig = (ch >= crdi2s_pkg::CH_ZERO) && (ch <= crdi2s_pkg::CH_NINE);
    is_ws  = (ch == crdi2s_pkg::CH_SPACE) ||
             ((ch >= crdi2s_pkg::CH_TAB) && (ch <= crdi2s_pkg::CH_CR));
    dval   = 4'(ch - crdi2s_pkg::CH_ZERO);
    f_ph   = phase_r;
    f_neg  = neg_r;
    f_val  = val_r;
    if (phase_r == crdi2s_pkg::PH_SKIP) begin
      if (is_ws) begin
        f_ph = phase_r;
      end else if ((ch == crdi2s_pkg::CH_PLUS) || (ch == crdi2s_pkg::CH_MINUS)) begin
        f_neg = (ch == crdi2s_pkg::CH_MINUS);
        f_ph  = crdi2s_pkg::PH_DIGITS;
      end else if (is_dig) begin
        f_val = 21'(dval);
        f_ph  = crdi2s_pkg::PH_DIGITS;
      end else begin
        f_ph = crdi2s_pkg::PH_DONE;
      end
    end else if (phase_r == crdi2s_pkg::PH_DIGITS) begin
      if (is_dig) begin
        f_val = 21'((25'(val_r) << 3) + (25'(val_r) << 1) + 25'(dval));
      end else begin
        f_ph = crdi2s_pkg::PH_DONE;
      end
    end
  end

  // record sequencing
  always_comb begin
    in_field = ((pos_r >= crdi2s_pkg::POS_X_BEGIN) && (pos_r <= crdi2s_pkg::POS_X_END)) ||
               ((pos_r >= crdi2s_pkg::POS_Y_BEGIN) && (pos_r <= crdi2s_pkg::POS_Y_END));
    pos_nxt    = (pos_r == crdi2s_pkg::POS_LAST) ? crdi2s_pkg::POS_FIRST : pos_r + 4'd1;
    kind_nxt   = kind_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    val_nxt    = val_r;
    xh_nxt     = xh_r;
    ev_vld_nxt = 1'b0;
    ev_frm_nxt = 1'b0;
    if (pos_r == crdi2s_pkg::POS_FIRST) begin
      if (ch == crdi2s_pkg::CH_C) begin
        kind_nxt = crdi2s_pkg::KIND_COORD;
      end else if (ch == crdi2s_pkg::CH_Z) begin
        kind_nxt = crdi2s_pkg::KIND_FRAME;
      end else begin
        kind_nxt = crdi2s_pkg::KIND_NONE;
      end
      phase_nxt = crdi2s_pkg::PH_SKIP;
      neg_nxt   = 1'b0;
      val_nxt   = '0;
    end else if (kind_r == crdi2s_pkg::KIND_COORD) begin
      if (in_field) begin
        phase_nxt = f_ph;
        neg_nxt   = f_neg;
        val_nxt   = f_val;
      end
      if (pos_r == crdi2s_pkg::POS_X_END) begin
        xh_nxt    = field_value(f_neg, f_val);
        phase_nxt = crdi2s_pkg::PH_SKIP;
        neg_nxt   = 1'b0;
        val_nxt   = '0;
      end else if (pos_r == crdi2s_pkg::POS_LAST) begin
        ev_vld_nxt = 1'b1;
        phase_nxt  = crdi2s_pkg::PH_SKIP;
        neg_nxt    = 1'b0;
        val_nxt    = '0;
      end
    end else if ((kind_r == crdi2s_pkg::KIND_FRAME) && (pos_r == crdi2s_pkg::POS_LAST)) begin
      ev_vld_nxt = 1'b1;
      ev_frm_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= crdi2s_pkg::POS_FIRST;
      kind_r    <= crdi2s_pkg::KIND_NONE;
      phase_r   <= crdi2s_pkg::PH_SKIP;
      neg_r     <= 1'b0;
      val_r     <= '0;
      xh_r      <= '0;
      ev_vld_r  <= 1'b0;
      ev_frm_r  <= 1'b0;
      tag_vld_r <= '0;
      tag_frm_r <= '0;
    end else begin
      if (in_acc) begin
        pos_r   <= pos_nxt;
        kind_r  <= kind_nxt;
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        val_r   <= val_nxt;
        xh_r    <= xh_nxt;
      end
      ev_vld_r  <= in_acc && ev_vld_nxt;
      ev_frm_r  <= ev_frm_nxt;
      tag_vld_r <= {tag_vld_r[crdi2s_pkg::SCALE_STAGES-2:0], ev_vld_r};
      tag_frm_r <= {tag_frm_r[crdi2s_pkg::SCALE_STAGES-2:0], ev_frm_r};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && ev_vld_nxt) begin
      ev_x_r <= xh_r;
      ev_y_r <= field_value(neg_r, val_r);
    end
  end

  crdi2s_scale u_scale_x (
    .clk (clk),
    .v   (ev_x_r),
    .c   (cx)
  );

  crdi2s_scale u_scale_y (
    .clk (clk),
    .v   (ev_y_r),
    .c   (cy)
  );

  // pack words, count stored words
  always_comb begin
    push_coord = tag_vld_r[crdi2s_pkg::SCALE_STAGES-1] && !tag_frm_r[crdi2s_pkg::SCALE_STAGES-1];
    push_frame = tag_vld_r[crdi2s_pkg::SCALE_STAGES-1] && tag_frm_r[crdi2s_pkg::SCALE_STAGES-1];
    wc_chain[0] = wc_r;
    for (int i = 0; i < 4; i++) begin
      ovf[i] = wc_chain[i] >= crdi2s_pkg::BUFFER_WORDS;
      wc_chain[i+1] = ovf[i] ? wc_chain[i] : wc_chain[i] + 16'd1;
    end
    wr_ent[0].out_word = {cx[26], cx[22:8]};
    wr_ent[1].out_word = {cx[7:0], 8'h00};
    wr_ent[2].out_word = {cy[26], cy[22:8]};
    wr_ent[3].out_word = {cy[7:0], 8'h00};
    for (int i = 0; i < 4; i++) begin
      wr_ent[i].is_frame_end = 1'b0;
      wr_ent[i].frame_length = '0;
      wr_ent[i].overflow     = ovf[i];
      wr_ent[i].last         = (i == 3);
    end
    push_n = 3'd0;
    wc_nxt = wc_r;
    if (push_coord) begin
      push_n = 3'd4;
      wc_nxt = wc_chain[4];
    end else if (push_frame) begin
      push_n = 3'd1;
      wc_nxt = '0;
      wr_ent[0].out_word     = '0;
      wr_ent[0].is_frame_end = 1'b1;
      wr_ent[0].frame_length = {wc_r[15:3], 1'b0};
      wr_ent[0].overflow     = 1'b0;
      wr_ent[0].last         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < push_n) begin
        mem_r[ADDR_W'(wptr_r + ADDR_W'(i))] <= wr_ent[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
      wc_r   <= '0;
    end else begin
      wptr_r <= ADDR_W'(wptr_r + ADDR_W'(push_n));
      rptr_r <= rptr_r + ADDR_W'(out_acc);
      cnt_r  <= cnt_r + CNT_W'(push_n) - CNT_W'(out_acc);
      wc_r   <= wc_nxt;
    end
  end

  assign out_ch.valid        = cnt_r != '0;
  assign out_ch.out_word     = mem_r[rptr_r].out_word;
  assign out_ch.is_frame_end = mem_r[rptr_r].is_frame_end;
  assign out_ch.frame_length = mem_r[rptr_r].frame_length;
  assign out_ch.overflow     = mem_r[rptr_r].overflow;
  assign out_ch.last         = mem_r[rptr_r].last;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 3'd0 |-> ({1'b0, cnt_r} + (CNT_W + 1)'(push_n)) <= (CNT_W + 1)'(FIFO_DEPTH))
    else $error("result queue push without room");

  a_one_record: assert property (@(posedge clk) disable iff (!rst_n)
    ev_vld_r |-> tag_vld_r == '0)
    else $error("two records in the scaling pipeline");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= crdi2s_pkg::POS_LAST)
    else $error("record position out of range");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    push_frame |=> wc_r == '0)
    else $error("word count not cleared after frame end");
`endif

endmodule
